FILE: rtl/core/iptp_pkg.sv
// Shared types and constants for the IP address text parser.
package iptp_pkg;

	localparam int ADDR_BYTES = 16;
	localparam int LENGTH_LIMIT_DEF = 63;

	typedef struct packed {
		logic [7:0] text_char;
		logic       start_new;
		logic       end_of_data;
		logic       family;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  parse_status;
		logic [5:0]  consumed_length;
		logic [63:0] address_high;
		logic [63:0] address_low;
	} out_item_t;

	localparam logic [1:0] ST_PARSING = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;

	localparam logic [6:0] AL_XDIGIT  = 7'h01;
	localparam logic [6:0] AL_DOT     = 7'h02;
	localparam logic [6:0] AL_DELIM   = 7'h04;
	localparam logic [6:0] AL_COLON1  = 7'h08;
	localparam logic [6:0] AL_COLON2  = 7'h10;
	localparam logic [6:0] AL_COLON12 = 7'h20;
	localparam logic [6:0] AL_FIRST   = 7'h40;
	localparam logic [6:0] AL_COLONS  = 7'h38;

	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;

	typedef enum logic [2:0] {
		K_DELIM = 3'd0,
		K_COLON = 3'd1,
		K_DOT   = 3'd2,
		K_HEX   = 3'd3,
		K_DEC   = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_V4   = 5'b00010,
		PH_V6   = 5'b00100,
		PH_TAIL = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

endpackage

FILE: rtl/core/ip_address_text_parser_core.sv
// Top level of the IP address text parser: one character in, one result out.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one text character per item,
//   with start_new, end_of_data and family flags. Output channel (out_valid/
//   out_ready/out_item) returns exactly one result per item: status (parsing,
//   success, failure), consumed length and the 128-bit address.
//   cfg_wr_en/cfg_wr_data write require_brackets; write only while idle.
// Result: registered in the output register at the accepting edge.
// Throughput: one item per cycle while results are taken; the parse state and the
//   result register are updated together at the accepting edge, so a new item follows at once.
// Stall: in_ready stays high while the output register is empty or is being
//   taken this cycle; a stalled result holds and input waits behind it.
// Reset: clears the parse to idle, require_brackets to 1 and drops any result.
//   Characters before the first start item yield status parsing with zeros.
// After success or failure the final result repeats until the next start item.
module ip_address_text_parser_core #(
	parameter int LENGTH_LIMIT = iptp_pkg::LENGTH_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iptp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output iptp_pkg::out_item_t out_item,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);

	localparam int CW = $clog2(LENGTH_LIMIT + 2);
	localparam logic [CW-1:0] LIM = CW'(LENGTH_LIMIT);
	localparam logic [4:0] AB = 5'(iptp_pkg::ADDR_BYTES);

	// parse state
	logic                req_brackets_q;
	iptp_pkg::phase_t    phase_q;
	logic [6:0]          allowed_q;
	logic [15:0][7:0]    store_q;
	logic [4:0]          wpos_q;
	logic [4:0]          gpos_q;
	logic                gap_q;
	logic [15:0]         hex_q;
	logic [11:0]         dec_q;
	logic                tok_dec_q;
	logic                tok_ne_q;
	logic [2:0]          octets_q;
	logic [CW-1:0]       cc_q;
	logic [1:0]          fstat_q;
	logic [5:0]          hlen_q;
	logic [63:0]         hhigh_q;
	logic [63:0]         hlow_q;
	logic                out_valid_q;
	iptp_pkg::out_item_t out_item_q;

	iptp_pkg::phase_t    n_phase;
	logic [6:0]          n_allowed;
	logic [15:0][7:0]    n_store;
	logic [4:0]          n_wpos;
	logic [4:0]          n_gpos;
	logic                n_gap;
	logic [15:0]         n_hex;
	logic [11:0]         n_dec;
	logic                n_tok_dec;
	logic                n_tok_ne;
	logic [2:0]          n_octets;
	logic [CW-1:0]       n_cc;
	logic [1:0]          n_fstat;
	logic [5:0]          n_hlen;
	logic [63:0]         n_hhigh;
	logic [63:0]         n_hlow;
	iptp_pkg::out_item_t n_out;

	logic accept;
	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Close the gap: move bytes above the gap to the top of the address.
	function automatic logic [127:0] expand(input logic [127:0] s, input logic [4:0] wp,
			input logic [4:0] gp, input logic gp_on);
		logic [4:0]   e;
		logic [4:0]   g;
		logic [127:0] lo_m;
		logic [127:0] end_m;
		logic [127:0] up;
		e = (wp > AB) ? AB : wp;
		g = (gp > e) ? e : gp;
		lo_m  = ~({128{1'b1}} << {g, 3'b000});
		end_m = (e == AB) ? {128{1'b1}} : ~({128{1'b1}} << {e, 3'b000});
		up = ((s & end_m) >> {g, 3'b000}) << {(AB - e + g), 3'b000};
		if (gp_on) begin
			expand = (s & lo_m) | up;
		end else begin
			expand = s;
		end
	endfunction

	always_comb begin
		logic           process;
		iptp_pkg::kind_t kind;
		logic [3:0]     val;
		logic [7:0]     c;
		logic           eod;
		logic           do_finish;
		logic           do_count;
		logic [4:0]     idx;
		logic [6:0]     al;
		logic [15:0][7:0] dst;
		logic [CW-1:0]  flen;
		logic [11:0]    dmul;

		n_phase   = phase_q;
		n_allowed = allowed_q;
		n_store   = store_q;
		n_wpos    = wpos_q;
		n_gpos    = gpos_q;
		n_gap     = gap_q;
		n_hex     = hex_q;
		n_dec     = dec_q;
		n_tok_dec = tok_dec_q;
		n_tok_ne  = tok_ne_q;
		n_octets  = octets_q;
		n_cc      = cc_q;
		n_fstat   = fstat_q;
		n_hlen    = hlen_q;
		n_hhigh   = hhigh_q;
		n_hlow    = hlow_q;
		process   = 1'b1;
		do_finish = 1'b0;
		do_count  = 1'b0;
		c   = in_item.text_char;
		eod = in_item.end_of_data;
		idx = '0;
		al  = allowed_q;
		dst = '0;
		flen = '0;
		dmul = '0;

		// classify the character
		val  = '0;
		kind = iptp_pkg::K_DELIM;
		if (!eod) begin
			if (c == iptp_pkg::CH_COLON) begin
				kind = iptp_pkg::K_COLON;
			end else if (c == iptp_pkg::CH_DOT) begin
				kind = iptp_pkg::K_DOT;
			end else if (c inside {["0":"9"]}) begin
				kind = iptp_pkg::K_DEC;
				val  = 4'(c - "0");
			end else if (c inside {["a":"f"]}) begin
				kind = iptp_pkg::K_HEX;
				val  = 4'(c - "a" + 8'd10);
			end else if (c inside {["A":"F"]}) begin
				kind = iptp_pkg::K_HEX;
				val  = 4'(c - "A" + 8'd10);
			end
		end

		// clear the parse on a start item
		if (in_item.start_new) begin
			n_allowed = iptp_pkg::AL_COLON12 | iptp_pkg::AL_XDIGIT | iptp_pkg::AL_FIRST;
			n_store   = '0;
			n_wpos    = '0;
			n_gpos    = '0;
			n_gap     = 1'b0;
			n_hex     = '0;
			n_dec     = '0;
			n_tok_dec = 1'b1;
			n_tok_ne  = 1'b0;
			n_octets  = '0;
			n_cc      = '0;
			n_fstat   = iptp_pkg::ST_PARSING;
			n_hlen    = '0;
			n_hhigh   = '0;
			n_hlow    = '0;
			al        = n_allowed;
			if (!in_item.family) begin
				n_phase = iptp_pkg::PH_V4;
			end else begin
				n_phase = iptp_pkg::PH_V6;
				if (!eod && c == iptp_pkg::CH_LBRACK) begin
					n_cc    = CW'(1);
					process = 1'b0;
				end else if (req_brackets_q) begin
					n_phase = iptp_pkg::PH_DONE;
					n_fstat = iptp_pkg::ST_FAIL;
					process = 1'b0;
				end
			end
		end

		dmul = {n_dec[8:0], 3'b000} + {n_dec[10:0], 1'b0} + 12'(val);

		if (process && (n_phase == iptp_pkg::PH_V4 || n_phase == iptp_pkg::PH_TAIL)) begin
			if (kind == iptp_pkg::K_HEX) begin
				n_phase = iptp_pkg::PH_DONE;
				n_fstat = iptp_pkg::ST_FAIL;
			end else if (kind == iptp_pkg::K_DEC) begin
				n_dec    = dmul;
				n_tok_ne = 1'b1;
				if (dmul > 12'd255) begin
					n_phase = iptp_pkg::PH_DONE;
					n_fstat = iptp_pkg::ST_FAIL;
				end else begin
					do_count = 1'b1;
				end
			end else if (!n_tok_ne) begin
				n_phase = iptp_pkg::PH_DONE;
				n_fstat = iptp_pkg::ST_FAIL;
			end else begin
				idx = ((n_phase == iptp_pkg::PH_TAIL) ? n_wpos : 5'd0) + {3'b000, n_octets[1:0]};
				if (idx < AB) begin
					n_store[idx[3:0]] = n_dec[7:0];
				end
				n_octets = n_octets + 3'd1;
				n_dec    = '0;
				n_tok_ne = 1'b0;
				if (kind == iptp_pkg::K_DOT) begin
					if (n_octets >= 3'd4) begin
						n_phase = iptp_pkg::PH_DONE;
						n_fstat = iptp_pkg::ST_FAIL;
					end else begin
						do_count = 1'b1;
					end
				end else if (n_octets != 3'd4) begin
					n_phase = iptp_pkg::PH_DONE;
					n_fstat = iptp_pkg::ST_FAIL;
				end else if (n_phase == iptp_pkg::PH_TAIL) begin
					n_wpos    = n_wpos + 5'd4;
					do_finish = 1'b1;
				end else begin
					flen    = n_cc;
					n_phase = iptp_pkg::PH_DONE;
					n_fstat = iptp_pkg::ST_OK;
					n_hlen  = 6'(flen);
					n_hhigh = '0;
					n_hlow  = {32'd0, n_store[0], n_store[1], n_store[2], n_store[3]};
				end
			end
		end else if (process && n_phase == iptp_pkg::PH_V6) begin
			if (!(((kind == iptp_pkg::K_DELIM) && (al & iptp_pkg::AL_DELIM) != '0)
					|| ((kind == iptp_pkg::K_COLON) && (al & iptp_pkg::AL_COLONS) != '0)
					|| ((kind == iptp_pkg::K_DOT) && (al & iptp_pkg::AL_DOT) != '0)
					|| ((kind == iptp_pkg::K_HEX || kind == iptp_pkg::K_DEC)
						&& (al & iptp_pkg::AL_XDIGIT) != '0))) begin
				n_phase = iptp_pkg::PH_DONE;
				n_fstat = iptp_pkg::ST_FAIL;
			end else if (kind == iptp_pkg::K_DELIM || kind == iptp_pkg::K_COLON) begin
				if ((al & iptp_pkg::AL_FIRST) == '0 && n_wpos < AB - 5'd1) begin
					n_store[n_wpos[3:0]]        = n_hex[15:8];
					n_store[4'(n_wpos + 5'd1)]  = n_hex[7:0];
					n_wpos = n_wpos + 5'd2;
				end
				n_hex = '0;
				if (kind == iptp_pkg::K_DELIM) begin
					do_finish = 1'b1;
				end else begin
					case (al & iptp_pkg::AL_COLONS)
						iptp_pkg::AL_COLON2: begin
							n_gap  = 1'b1;
							n_gpos = n_wpos;
							al = iptp_pkg::AL_XDIGIT | iptp_pkg::AL_DELIM;
							if (n_wpos >= AB) begin
								al = al | iptp_pkg::AL_FIRST;
							end
						end
						iptp_pkg::AL_COLON1 | iptp_pkg::AL_COLON12: begin
							al = iptp_pkg::AL_XDIGIT | iptp_pkg::AL_COLON2;
						end
						iptp_pkg::AL_COLON1:  al = iptp_pkg::AL_XDIGIT;
						iptp_pkg::AL_COLON12: al = iptp_pkg::AL_COLON2;
						default:              al = '0;
					endcase
					n_dec     = '0;
					n_tok_dec = 1'b1;
					n_tok_ne  = 1'b0;
					do_count  = 1'b1;
				end
			end else if (kind == iptp_pkg::K_DOT) begin
				if (!n_tok_dec || !n_tok_ne || n_dec > 12'd255 || n_wpos > AB - 5'd4) begin
					n_phase = iptp_pkg::PH_DONE;
					n_fstat = iptp_pkg::ST_FAIL;
				end else begin
					n_store[n_wpos[3:0]] = n_dec[7:0];
					n_octets = 3'd1;
					n_dec    = '0;
					n_tok_ne = 1'b0;
					n_phase  = iptp_pkg::PH_TAIL;
					n_cc     = (n_cc < LIM) ? n_cc + CW'(1) : n_cc;
				end
			end else begin
				n_hex    = {n_hex[11:0], val};
				n_tok_ne = 1'b1;
				if (kind == iptp_pkg::K_HEX) begin
					n_tok_dec = 1'b0;
				end else if (n_dec <= 12'd255) begin
					n_dec = dmul;
				end
				al = iptp_pkg::AL_COLON1 | iptp_pkg::AL_DELIM;
				if (n_hex[15:12] == 4'd0) begin
					al = al | iptp_pkg::AL_XDIGIT;
				end
				if (!n_gap && n_wpos < AB - 5'd2) begin
					al = (al | iptp_pkg::AL_COLON12) & ~iptp_pkg::AL_DELIM;
				end
				if (n_wpos >= AB - 5'd2) begin
					al = al & ~(iptp_pkg::AL_COLON1 | iptp_pkg::AL_COLON12);
				end
				do_count = 1'b1;
			end
			// common tail of a colon or digit step
			if (do_count) begin
				if ((n_gap && n_wpos < AB - 5'd4) || n_wpos == AB - 5'd4) begin
					al = al | iptp_pkg::AL_DOT;
				end
				if (n_wpos >= AB) begin
					al = al & ~(iptp_pkg::AL_XDIGIT | iptp_pkg::AL_COLONS);
				end
				n_allowed = al;
			end
		end

		if (do_count) begin
			n_cc = (n_cc < LIM) ? n_cc + CW'(1) : n_cc;
		end

		// assemble the IPv6 result
		if (do_finish) begin
			dst = expand(n_store, n_wpos, n_gpos, n_gap);
			n_phase = iptp_pkg::PH_DONE;
			if (!eod && c == iptp_pkg::CH_RBRACK) begin
				flen = n_cc + CW'(1);
				n_fstat = iptp_pkg::ST_OK;
			end else if (req_brackets_q) begin
				n_fstat = iptp_pkg::ST_FAIL;
			end else begin
				flen = n_cc;
				n_fstat = iptp_pkg::ST_OK;
			end
			if (n_fstat == iptp_pkg::ST_OK) begin
				n_hlen = 6'((flen > LIM) ? LIM : flen);
				for (int k = 0; k < 8; k++) begin
					n_hhigh[63-8*k -: 8] = dst[k];
					n_hlow[63-8*k -: 8]  = dst[k+8];
				end
			end
		end

		if (n_phase == iptp_pkg::PH_DONE) begin
			n_out.parse_status    = n_fstat;
			n_out.consumed_length = (n_fstat == iptp_pkg::ST_OK) ? n_hlen : 6'd0;
			n_out.address_high    = (n_fstat == iptp_pkg::ST_OK) ? n_hhigh : 64'd0;
			n_out.address_low     = (n_fstat == iptp_pkg::ST_OK) ? n_hlow : 64'd0;
		end else begin
			n_out = '0;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_brackets_q <= 1'b1;
		end else if (cfg_wr_en) begin
			req_brackets_q <= cfg_wr_data;
		end
	end

	// advance the parse state on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= iptp_pkg::PH_IDLE;
			allowed_q <= iptp_pkg::AL_COLON12 | iptp_pkg::AL_XDIGIT | iptp_pkg::AL_FIRST;
			store_q   <= '0;
			wpos_q    <= '0;
			gpos_q    <= '0;
			gap_q     <= 1'b0;
			hex_q     <= '0;
			dec_q     <= '0;
			tok_dec_q <= 1'b1;
			tok_ne_q  <= 1'b0;
			octets_q  <= '0;
			cc_q      <= '0;
			fstat_q   <= iptp_pkg::ST_PARSING;
			hlen_q    <= '0;
			hhigh_q   <= '0;
			hlow_q    <= '0;
		end else if (accept) begin
			phase_q   <= n_phase;
			allowed_q <= n_allowed;
			store_q   <= n_store;
			wpos_q    <= n_wpos;
			gpos_q    <= n_gpos;
			gap_q     <= n_gap;
			hex_q     <= n_hex;
			dec_q     <= n_dec;
			tok_dec_q <= n_tok_dec;
			tok_ne_q  <= n_tok_ne;
			octets_q  <= n_octets;
			cc_q      <= n_cc;
			fstat_q   <= n_fstat;
			hlen_q    <= n_hlen;
			hhigh_q   <= n_hhigh;
			hlow_q    <= n_hlow;
		end
	end

	// output register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q <= n_out;
		end
	end

`ifndef ASSERT_OFF
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while result stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.parse_status == iptp_pkg::ST_PARSING
			|| out_item.parse_status == iptp_pkg::ST_OK
			|| out_item.parse_status == iptp_pkg::ST_FAIL))
		else $error("unknown status code");

	a_length_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.parse_status != iptp_pkg::ST_OK) |->
			(out_item.consumed_length == 6'd0))
		else $error("length reported without success");

	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= AB)
		else $error("write position beyond address");
`endif

endmodule

FILE: verif/tb_ip_address_text_parser_core.sv
// Self-checking testbench for the IP address text parser core.
import iptp_pkg::*;

// Parse predictor and store of expected results.
class parse_scoreboard;
	out_item_t   expected_results[$];
	int          mismatches;
	int          results_seen;
	int          successes;
	int          failures;
	bit          brackets_required;
	phase_t      phase;
	logic [6:0]  allowed;
	logic [7:0]  octets[ADDR_BYTES];
	int          wpos;
	int          gpos;
	bit          gap_seen;
	logic [15:0] hex_acc;
	int          dec_acc;
	bit          tok_decimal;
	bit          tok_nonempty;
	int          octet_count;
	int          char_count;
	logic [1:0]  status;
	int          held_len;
	logic [63:0] held_high;
	logic [63:0] held_low;

	function new();
		brackets_required = 1;
		clear_parse();
	endfunction

	function void clear_token();
		dec_acc = 0;
		tok_decimal = 1;
		tok_nonempty = 0;
	endfunction

	function void clear_parse();
		phase = PH_IDLE;
		allowed = AL_COLON12 | AL_XDIGIT | AL_FIRST;
		foreach (octets[i]) octets[i] = 0;
		wpos = 0;
		gpos = 0;
		gap_seen = 0;
		hex_acc = 0;
		clear_token();
		octet_count = 0;
		char_count = 0;
		status = ST_PARSING;
		held_len = 0;
		held_high = 0;
		held_low = 0;
	endfunction

	function void bump_count();
		if (char_count < LENGTH_LIMIT_DEF) char_count++;
	endfunction

	function void fail_parse();
		phase = PH_DONE;
		status = ST_FAIL;
		held_len = 0;
		held_high = 0;
		held_low = 0;
	endfunction

	function void succeed(int len);
		phase = PH_DONE;
		status = ST_OK;
		held_len = (len > LENGTH_LIMIT_DEF) ? LENGTH_LIMIT_DEF : len;
	endfunction

	function kind_t classify(logic [7:0] c, bit eod, output int val);
		val = 0;
		if (eod) return K_DELIM;
		if (c == CH_COLON) return K_COLON;
		if (c == CH_DOT) return K_DOT;
		if (c >= "0" && c <= "9") begin
			val = c - "0";
			return K_DEC;
		end
		if (c >= "a" && c <= "f") begin
			val = c - "a" + 10;
			return K_HEX;
		end
		if (c >= "A" && c <= "F") begin
			val = c - "A" + 10;
			return K_HEX;
		end
		return K_DELIM;
	endfunction

	// Close an IPv6 parse: expand the gap, then settle the bracket rule.
	function void finish_v6(logic [7:0] c, bit eod);
		logic [7:0] dst[ADDR_BYTES];
		int last, g, tl;
		foreach (dst[i]) dst[i] = 0;
		last = (wpos > ADDR_BYTES) ? ADDR_BYTES : wpos;
		if (gap_seen) begin
			g = (gpos > last) ? last : gpos;
			tl = last - g;
			for (int k = 0; k < g; k++) dst[k] = octets[k];
			for (int k = 0; k < tl; k++) dst[ADDR_BYTES - tl + k] = octets[g + k];
		end else begin
			foreach (dst[i]) dst[i] = octets[i];
		end
		if (!eod && c == CH_RBRACK) begin
			succeed(char_count + 1);
		end else if (brackets_required) begin
			fail_parse();
			return;
		end else begin
			succeed(char_count);
		end
		held_high = 0;
		held_low = 0;
		for (int k = 0; k < 8; k++) begin
			held_high = {held_high[55:0], dst[k]};
			held_low = {held_low[55:0], dst[k + 8]};
		end
	endfunction

	function void step_dotted(kind_t kind, int val, int base, bit tail_mode,
			logic [7:0] c, bit eod);
		int idx;
		if (kind == K_HEX) begin
			fail_parse();
			return;
		end
		if (kind == K_DEC) begin
			dec_acc = dec_acc * 10 + val;
			tok_nonempty = 1;
			if (dec_acc > 255) begin
				fail_parse();
				return;
			end
			bump_count();
			return;
		end
		if (!tok_nonempty) begin
			fail_parse();
			return;
		end
		idx = base + (octet_count & 3);
		if (idx < ADDR_BYTES) octets[idx] = dec_acc[7:0];
		octet_count++;
		dec_acc = 0;
		tok_nonempty = 0;
		if (kind == K_DOT) begin
			if (octet_count >= 4) fail_parse();
			else bump_count();
			return;
		end
		if (octet_count != 4) begin
			fail_parse();
			return;
		end
		if (tail_mode) begin
			wpos += 4;
			finish_v6(c, eod);
		end else begin
			succeed(char_count);
			held_high = 0;
			held_low = {32'd0, octets[0], octets[1], octets[2], octets[3]};
		end
	endfunction

	function void step_v6(kind_t kind, int val, logic [7:0] c, bit eod);
		logic [6:0] need, al;
		al = allowed;
		need = (kind == K_DELIM) ? AL_DELIM : (kind == K_COLON) ? AL_COLONS :
			(kind == K_DOT) ? AL_DOT : AL_XDIGIT;
		if ((al & need) == 0) begin
			fail_parse();
			return;
		end
		if (kind == K_DELIM || kind == K_COLON) begin
			if ((al & AL_FIRST) == 0 && wpos + 1 < ADDR_BYTES) begin
				octets[wpos] = hex_acc[15:8];
				octets[wpos + 1] = hex_acc[7:0];
				wpos += 2;
			end
			hex_acc = 0;
			if (kind == K_DELIM) begin
				finish_v6(c, eod);
				return;
			end
			case (al & AL_COLONS)
				AL_COLON2: begin
					gap_seen = 1;
					gpos = wpos;
					al = AL_XDIGIT | AL_DELIM;
					if (gpos >= ADDR_BYTES) al |= AL_FIRST;
				end
				AL_COLON1 | AL_COLON12: al = AL_XDIGIT | AL_COLON2;
				AL_COLON1: al = AL_XDIGIT;
				AL_COLON12: al = AL_COLON2;
				default: al = 0;
			endcase
			clear_token();
		end else if (kind == K_DOT) begin
			if (!tok_decimal || !tok_nonempty || dec_acc > 255 || wpos + 4 > ADDR_BYTES) begin
				fail_parse();
				return;
			end
			octets[wpos] = dec_acc[7:0];
			octet_count = 1;
			dec_acc = 0;
			tok_nonempty = 0;
			phase = PH_TAIL;
			bump_count();
			return;
		end else begin
			hex_acc = {hex_acc[11:0], val[3:0]};
			tok_nonempty = 1;
			if (kind == K_HEX) tok_decimal = 0;
			else if (dec_acc <= 255) dec_acc = dec_acc * 10 + val;
			al = AL_COLON1 | AL_DELIM;
			if ((hex_acc & 16'hf000) == 0) al |= AL_XDIGIT;
			if (!gap_seen && wpos + 2 < ADDR_BYTES) begin
				al |= AL_COLON12;
				al &= ~AL_DELIM;
			end
			if (wpos + 2 >= ADDR_BYTES) al &= ~(AL_COLON1 | AL_COLON12);
		end
		if ((gap_seen && wpos + 4 < ADDR_BYTES) || wpos + 4 == ADDR_BYTES) al |= AL_DOT;
		if (wpos >= ADDR_BYTES) al &= ~(AL_XDIGIT | AL_COLONS);
		allowed = al;
		bump_count();
	endfunction

	// Advance the predicted parse by one accepted item and queue its result.
	function void note_input(in_item_t it);
		out_item_t r;
		kind_t kind;
		int val;
		bit go;
		go = 1;
		if (it.start_new) begin
			clear_parse();
			if (!it.family) begin
				phase = PH_V4;
			end else begin
				phase = PH_V6;
				if (!it.end_of_data && it.text_char == CH_LBRACK) begin
					bump_count();
					go = 0;
				end else if (brackets_required) begin
					fail_parse();
					go = 0;
				end
			end
		end
		if (go && (phase == PH_V4 || phase == PH_V6 || phase == PH_TAIL)) begin
			kind = classify(it.text_char, it.end_of_data, val);
			if (phase == PH_V4) step_dotted(kind, val, 0, 0, it.text_char, it.end_of_data);
			else if (phase == PH_TAIL)
				step_dotted(kind, val, wpos, 1, it.text_char, it.end_of_data);
			else step_v6(kind, val, it.text_char, it.end_of_data);
		end
		r = '0;
		if (phase == PH_DONE) begin
			r.parse_status = status;
			r.consumed_length = held_len[5:0];
			r.address_high = held_high;
			r.address_low = held_low;
		end
		expected_results.push_back(r);
	endfunction

	task report(string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task check(out_item_t got);
		out_item_t exp;
		if (expected_results.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		exp = expected_results.pop_front();
		results_seen++;
		if (exp.parse_status == ST_OK) successes++;
		if (exp.parse_status == ST_FAIL) failures++;
		if (got.parse_status !== exp.parse_status)
			report($sformatf("status %0d, want %0d", got.parse_status, exp.parse_status));
		if (got.consumed_length !== exp.consumed_length)
			report($sformatf("length %0d, want %0d", got.consumed_length,
				exp.consumed_length));
		if (got.address_high !== exp.address_high)
			report($sformatf("high %h, want %h", got.address_high, exp.address_high));
		if (got.address_low !== exp.address_low)
			report($sformatf("low %h, want %h", got.address_low, exp.address_low));
	endtask
endclass

module tb_ip_address_text_parser_core;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1550;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_wr_en;
	logic      cfg_wr_data;

	parse_scoreboard sb;
	in_item_t        text_items[$];
	int              items_sent;
	int              cycle_count;
	int              addresses;
	bit              steady;
	bit              hold_off;

	ip_address_text_parser_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[ip_address_text_parser_core] ERROR");
			$finish;
		end
	end

	// Receiver: stall at random, but never in a steady stretch and always in a hold-off.
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (hold_off) out_ready <= 0;
		else out_ready <= steady || ($urandom_range(0, 99) >= 7);
	end

	// Check every result taken by the receiver.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check(out_item);
	end

	// Hold off the receiver for a long stretch while text keeps coming, so the
	// output register fills and the input stalls behind it.
	initial begin
		hold_off = 0;
		wait (items_sent >= 300);
		@(posedge clk);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	// Queue one address text: first character carries start, then the
	// terminator (end of data or a stray delimiter), then a few ignored bytes.
	task queue_text(string s, bit fam, bit eod_end, int noise);
		in_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.text_char = s[i];
			it.start_new = (i == 0);
			it.end_of_data = 0;
			it.family = fam;
			text_items.push_back(it);
		end
		it.text_char = 8'($urandom_range(0, 255));
		it.start_new = (s.len() == 0);
		it.family = fam;
		if (eod_end || s.len() == 0) begin
			it.end_of_data = 1;
		end else begin
			it.end_of_data = 0;
			case ($urandom_range(0, 3))
				0: it.text_char = " ";
				1: it.text_char = ",";
				2: it.text_char = "/";
				default: it.text_char = 8'h80 | 8'($urandom_range(0, 127));
			endcase
		end
		text_items.push_back(it);
		repeat (noise) begin
			it.text_char = 8'($urandom_range(0, 255));
			it.start_new = 0;
			it.end_of_data = 1'($urandom_range(0, 1));
			it.family = 1'($urandom_range(0, 1));
			text_items.push_back(it);
		end
		addresses++;
	endtask

	function string hex_group();
		string g;
		int w;
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
		g = ($urandom_range(0, 3) == 0) ? $sformatf("%04h", w) : $sformatf("%0h", w);
		if ($urandom_range(0, 1)) g = g.toupper();
		return g;
	endfunction

	function string dotted_quad();
		string s;
		int o;
		s = "";
		for (int i = 0; i < 4; i++) begin
			o = ($urandom_range(0, 4) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
			s = {s, (i != 0) ? "." : "", ($urandom_range(0, 9) == 0) ?
				$sformatf("%03d", o) : $sformatf("%0d", o)};
		end
		return s;
	endfunction

	// Well-formed IPv6 text, with an optional gap and dotted tail.
	function string v6_text();
		string s;
		bit has_gap, has_tail, right_any;
		int nw, gs, gl;
		has_tail = ($urandom_range(0, 3) == 0);
		has_gap = 1'($urandom_range(0, 1));
		nw = has_tail ? 6 : 8;
		gs = nw;
		gl = 0;
		if (has_gap) begin
			gs = $urandom_range(0, nw - 1);
			gl = $urandom_range(1, nw - gs);
		end
		s = "";
		for (int i = 0; i < gs; i++) s = {s, (i != 0) ? ":" : "", hex_group()};
		if (has_gap) s = {s, "::"};
		right_any = 0;
		for (int i = gs + gl; i < nw; i++) begin
			s = {s, right_any ? ":" : "", hex_group()};
			right_any = 1;
		end
		if (has_tail) s = {s, (!has_gap || right_any) ? ":" : "", dotted_quad()};
		return s;
	endfunction

	// Break a string now and then by overwriting one character.
	function string damage(string s);
		string alphabet;
		alphabet = ":.0123456789abcdefAFG[]";
		if (s.len() > 0 && $urandom_range(0, 4) == 0)
			s[$urandom_range(0, s.len() - 1)] = alphabet[$urandom_range(0, alphabet.len() - 1)];
		return s;
	endfunction

	task queue_random_address();
		string s;
		bit fam, brk;
		fam = 1'($urandom_range(0, 1));
		if (!fam) begin
			s = damage(dotted_quad());
		end else begin
			brk = sb.brackets_required ? ($urandom_range(0, 19) != 0) :
				1'($urandom_range(0, 1));
			s = damage(brk ? {"[", v6_text(), "]"} : v6_text());
		end
		queue_text(s, fam, 1'($urandom_range(0, 1)), $urandom_range(0, 2));
	endtask

	// Offer every queued item; hold valid and payload until each is taken.
	task send_queued();
		in_item_t it;
		while (text_items.size() > 0) begin
			it = text_items.pop_front();
			if (!steady && $urandom_range(0, 99) < 7) begin
				in_valid <= 0;
				@(posedge clk);
			end
			in_valid <= 1;
			in_item <= it;
			do @(posedge clk); while (!in_ready);
			sb.note_input(it);
			items_sent++;
		end
		in_valid <= 0;
	endtask

	// Wait for the block to drain, then write the bracket register.
	task set_brackets(bit v);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.brackets_required = v;
	endtask

	initial begin
		in_item_t it;
		string zeros;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_ready = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		steady = 0;
		items_sent = 0;
		cycle_count = 0;
		addresses = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Characters before any start are ignored.
		it = '{text_char: "1", start_new: 0, end_of_data: 0, family: 0};
		text_items.push_back(it);
		it = '{text_char: 8'hff, start_new: 0, end_of_data: 1, family: 1};
		text_items.push_back(it);

		// Directed cases with brackets required.
		queue_text("0.0.0.0", 0, 1, 0);
		queue_text("255.255.255.255", 0, 0, 1);
		queue_text("256.1.1.1", 0, 1, 0);
		queue_text("1.2.3", 0, 1, 0);
		queue_text("1.2.3.4.5", 0, 0, 0);
		queue_text("1..2.3", 0, 1, 0);
		queue_text("1.a.3.4", 0, 1, 0);
		queue_text("10.2.3.4:80", 0, 1, 0);
		zeros = "";
		repeat (70) zeros = {zeros, "0"};
		queue_text({zeros, "1.2.3.4"}, 0, 1, 0);
		queue_text("", 0, 1, 0);
		queue_text("", 1, 1, 0);
		queue_text("[::]", 1, 0, 2);
		queue_text("[::1]", 1, 1, 0);
		queue_text("[1:2:3:4:5:6:7:8]", 1, 0, 0);
		queue_text("[FFFF:ffff:ffff:ffff:ffff:ffff:ffff:ffff]", 1, 0, 0);
		queue_text("[::ffff:192.168.0.1]", 1, 0, 0);
		queue_text("[1:2:3:4:5:6:7:8:9]", 1, 0, 0);
		queue_text("[:::]", 1, 0, 0);
		queue_text("[12345::]", 1, 0, 0);
		queue_text("[", 1, 1, 0);
		queue_text("1::2", 1, 1, 0);
		queue_text("[1::2", 1, 1, 0);
		send_queued();

		// Brackets optional.
		set_brackets(0);
		queue_text("1::2", 1, 1, 0);
		queue_text("::", 1, 0, 0);
		queue_text("1:2:3:4:5:6:7:8]", 1, 0, 0);
		queue_text("1:2:3:4:5:6:1.2.3.4", 1, 1, 0);
		queue_text("", 1, 1, 0);
		send_queued();

		// Random phases, the bracket rule written before each of them; one phase
		// runs without any idling on either side.
		for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
			set_brackets(ph % 3 == 0);
			steady = (ph == 2);
			while (text_items.size() < 250) queue_random_address();
			send_queued();
		end
		steady = 0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d addresses in %0d items: %0d parsed, %0d rejected",
			addresses, items_sent, sb.successes, sb.failures);
		$display("bracket rule both ways, a long receiver hold-off, %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("[ip_address_text_parser_core] OK");
		else
			$display("[ip_address_text_parser_core] ERROR");
		$finish;
	end

endmodule
